[rtl/lpfp_pkg.sv]
package lpfp_pkg;

    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned CodeWidth  = 4;
    localparam int unsigned CfgIdxWidth = 2;

    // configuration register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_HEAD_VALUE        = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_TAIL_FIRST_VALUE  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_TAIL_SECOND_VALUE = 2'd2;

    localparam logic [ByteWidth-1:0] HEAD_VALUE_RST        = 8'd36;
    localparam logic [ByteWidth-1:0] TAIL_FIRST_VALUE_RST  = 8'd13;
    localparam logic [ByteWidth-1:0] TAIL_SECOND_VALUE_RST = 8'd10;

    typedef enum logic [CodeWidth-1:0] {
        PH_HEAD    = 4'd0,
        PH_SRC     = 4'd1,
        PH_CMD     = 4'd2,
        PH_IDLEN   = 4'd3,
        PH_ID      = 4'd4,
        PH_MACLEN  = 4'd5,
        PH_MAC     = 4'd6,
        PH_CONTLEN = 4'd7,
        PH_CONTENT = 4'd8,
        PH_SUM     = 4'd9,
        PH_END0    = 4'd10,
        PH_END1    = 4'd11
    } phase_t;

    typedef struct packed {
        logic [ByteWidth-1:0] in_byte;
        logic                 frame_start;
    } frame_in_t;

    typedef struct packed {
        logic [ByteWidth-1:0] out_byte;
        logic [CodeWidth-1:0] field_code;
        logic [ByteWidth-1:0] field_offset;
        logic                 frame_done;
        logic                 head_match;
        logic                 sum_match;
        logic                 tail_match;
    } frame_out_t;

endpackage

[rtl/length_prefixed_frame_parser.sv]
// Length-prefixed frame parser. Takes one byte per cycle on the input channel
// while in_stall is low and returns exactly one registered, tagged result per
// byte: the byte itself, the code of the frame field it falls in (head,
// source, command, three length/data pairs, checksum, two end bytes) and its
// offset inside that field. A running XOR covers head through content; on the
// second end byte frame_done rises together with the head, checksum and end
// byte checks. frame_start forces the byte to be taken as a new head. All
// per-byte work is one combinational step on the parser state, so a byte can
// be accepted every cycle while the one-entry skid register is empty; behind
// the output register, it absorbs one more byte while the output side stalls.
// Configuration registers must be written only while no request is in flight.
module length_prefixed_frame_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [lpfp_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [lpfp_pkg::ByteWidth-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lpfp_pkg::frame_in_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lpfp_pkg::frame_out_t                out_data
);

    logic [lpfp_pkg::ByteWidth-1:0] head_value_reg;
    logic [lpfp_pkg::ByteWidth-1:0] tail_first_value_reg;
    logic [lpfp_pkg::ByteWidth-1:0] tail_second_value_reg;

    lpfp_pkg::phase_t               phase_reg, phase_next;
    logic [lpfp_pkg::ByteWidth-1:0] bytes_left_reg, bytes_left_next;
    logic [lpfp_pkg::ByteWidth-1:0] position_reg, position_next;
    logic [lpfp_pkg::ByteWidth-1:0] xor_reg, xor_next;
    logic                           head_ok_reg, head_ok_next;
    logic                           sum_ok_reg, sum_ok_next;
    logic                           end0_ok_reg, end0_ok_next;

    lpfp_pkg::frame_out_t           out_reg, skid_reg, result;
    logic                           out_valid_reg, skid_valid_reg;

    lpfp_pkg::phase_t               ph;
    logic [lpfp_pkg::ByteWidth-1:0] b;
    logic [lpfp_pkg::ByteWidth-1:0] left_dec;
    logic                           in_acc, out_take;

    assign in_acc   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_value_reg        <= lpfp_pkg::HEAD_VALUE_RST;
            tail_first_value_reg  <= lpfp_pkg::TAIL_FIRST_VALUE_RST;
            tail_second_value_reg <= lpfp_pkg::TAIL_SECOND_VALUE_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                lpfp_pkg::CFG_HEAD_VALUE:        head_value_reg        <= cfg_data;
                lpfp_pkg::CFG_TAIL_FIRST_VALUE:  tail_first_value_reg  <= cfg_data;
                lpfp_pkg::CFG_TAIL_SECOND_VALUE: tail_second_value_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // per-byte parse step
    always_comb
    begin
        b  = in_data.in_byte;
        ph = in_data.frame_start ? lpfp_pkg::PH_HEAD : phase_reg;
        left_dec = bytes_left_reg - 8'd1;

        phase_next      = ph;
        bytes_left_next = bytes_left_reg;
        position_next   = position_reg;
        xor_next        = xor_reg;
        head_ok_next    = head_ok_reg;
        sum_ok_next     = sum_ok_reg;
        end0_ok_next    = end0_ok_reg;

        result.out_byte     = b;
        result.field_code   = ph;
        result.field_offset = '0;
        result.frame_done   = 1'b0;
        result.head_match   = 1'b0;
        result.sum_match    = 1'b0;
        result.tail_match   = 1'b0;

        case (ph)
            lpfp_pkg::PH_SRC: phase_next = lpfp_pkg::PH_CMD;
            lpfp_pkg::PH_CMD: phase_next = lpfp_pkg::PH_IDLEN;
            lpfp_pkg::PH_IDLEN, lpfp_pkg::PH_MACLEN, lpfp_pkg::PH_CONTLEN:
            begin
                bytes_left_next = b;
                position_next   = '0;
                // empty field: skip straight past its data phase
                phase_next = lpfp_pkg::phase_t'(ph + ((b != '0) ? 4'd1 : 4'd2));
            end
            lpfp_pkg::PH_ID, lpfp_pkg::PH_MAC, lpfp_pkg::PH_CONTENT:
            begin
                result.field_offset = position_reg;
                position_next   = position_reg + 8'd1;
                bytes_left_next = left_dec;
                if (left_dec == '0)
                begin
                    phase_next = lpfp_pkg::phase_t'(ph + 4'd1);
                end
            end
            lpfp_pkg::PH_SUM:
            begin
                sum_ok_next = (b == xor_reg);
                phase_next  = lpfp_pkg::PH_END0;
            end
            lpfp_pkg::PH_END0:
            begin
                end0_ok_next = (b == tail_first_value_reg);
                phase_next   = lpfp_pkg::PH_END1;
            end
            lpfp_pkg::PH_END1:
            begin
                result.frame_done = 1'b1;
                result.head_match = head_ok_reg;
                result.sum_match  = sum_ok_reg;
                result.tail_match = end0_ok_reg && (b == tail_second_value_reg);
                phase_next = lpfp_pkg::PH_HEAD;
            end
            default:
            begin
                // head, and any unused phase code
                result.field_code = lpfp_pkg::PH_HEAD;
                head_ok_next    = (b == head_value_reg);
                sum_ok_next     = 1'b0;
                end0_ok_next    = 1'b0;
                bytes_left_next = '0;
                position_next   = '0;
                xor_next        = b;
                phase_next      = lpfp_pkg::PH_SRC;
            end
        endcase

        if (ph != lpfp_pkg::PH_HEAD && ph <= lpfp_pkg::PH_CONTENT)
        begin
            xor_next = xor_reg ^ b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= lpfp_pkg::PH_HEAD;
            bytes_left_reg <= '0;
            position_reg   <= '0;
            xor_reg        <= '0;
            head_ok_reg    <= 1'b0;
            sum_ok_reg     <= 1'b0;
            end0_ok_reg    <= 1'b0;
        end
        else if (in_acc)
        begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            position_reg   <= position_next;
            xor_reg        <= xor_next;
            head_ok_reg    <= head_ok_next;
            sum_ok_reg     <= sum_ok_next;
            end0_ok_reg    <= end0_ok_next;
        end
    end

    // output register with one-entry skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_acc)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_acc)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_done_on_end1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.frame_done |->
            out_reg.field_code == lpfp_pkg::PH_END1)
        else $error("frame_done outside the second end byte");

    a_match_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.frame_done |->
            !out_reg.head_match && !out_reg.sum_match && !out_reg.tail_match)
        else $error("match flag set without frame_done");

    a_start_to_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_data.frame_start |=> phase_reg == lpfp_pkg::PH_SRC)
        else $error("frame start did not restart the parse");

    a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid entry filled while output was free");

endmodule
